// ===== sv/rdc_pkg.sv =====
// Shared constants and types of the radix digit converter.
`default_nettype none
package rdc_pkg;

  localparam int unsigned VALUE_W   = 64;  // input value width
  localparam int unsigned NIB_W     = 4;   // bits handled per datapath cycle
  localparam int unsigned NIBBLES   = VALUE_W / NIB_W;
  localparam int unsigned NIB_CNT_W = $clog2(NIBBLES);
  localparam int unsigned REM_W     = 5;   // remainder below a divisor of at most 16
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned RADIX_W   = 6;

  localparam logic signed [RADIX_W-1:0] RESET_RADIX = 6'sd10;
  localparam logic [RADIX_W-1:0]        MIN_RADIX   = 6'd2;

  // Commands from the sequencer to the serial datapath.
  typedef struct packed {
    logic load;       // take a new magnitude
    logic start_div;  // run one division pass, top nibble first
    logic start_inc;  // run one increment pass, low nibble first
  } dp_cmd_t;

  // Status of the serial datapath.
  typedef struct packed {
    logic             busy;
    logic             done;  // one-cycle pulse after the last nibble of a pass
    logic             nz;    // quotient of the last division pass is nonzero
    logic [REM_W-1:0] rem;   // remainder of the last division pass
  } dp_status_t;

endpackage
`default_nettype wire

// ===== sv/radix_digit_converter_top.sv =====
// Top level of the radix digit converter: sequencer, digit store and output register.
`default_nettype none
// Converts a signed 64-bit value into digits of the signed radix held in the
// configuration register (magnitude 2..MAX_RADIX, reset 10), most significant
// digit first, one output transaction per digit, the final one marked by
// last_digit_o. A radix outside that range gives one transaction with
// bad_radix_o set and digit 0. Zero gives the single digit 0. At most
// MAX_DIGITS low digits are kept. One value is converted at a time: each digit
// costs one nibble-serial division pass, plus an increment pass when the
// running value is negative and the remainder nonzero, and a negative input
// adds one negation pass up front. Read-out from the digit store then passes
// through S_READ and S_EMIT for each digit.
module radix_digit_converter_top import rdc_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 64,
  parameter int unsigned MAX_RADIX  = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic signed [RADIX_W-1:0] radix_i,
  // input channel
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic signed [VALUE_W-1:0] value_i,
  // output channel
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic             [DIGIT_W-1:0] digit_o,
  output logic                           last_digit_o,
  output logic                           bad_radix_o
);

  localparam int unsigned AW = $clog2(MAX_DIGITS);
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_NEG  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_INC  = 7'b0001000,
    S_READ = 7'b0010000,
    S_EMIT = 7'b0100000,
    S_ERR  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic signed [RADIX_W-1:0] radix_q;
  logic                      neg_q, neg_d;
  logic [CW-1:0]             count_q, count_d;
  logic [AW-1:0]             rd_idx_q, rd_idx_d;

  logic               out_valid_q, out_valid_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic               last_q, last_d;
  logic               bad_q, bad_d;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_st;
  logic [VALUE_W-1:0] dp_load_data;

  logic               ram_we;
  logic [DIGIT_W-1:0] ram_wdata;
  logic [DIGIT_W-1:0] ram_rdata;

  // radix magnitude and validity
  logic               radix_neg;
  logic [RADIX_W-1:0] radix_mag;
  logic               radix_bad;

  assign radix_neg = radix_q[RADIX_W-1];
  assign radix_mag = radix_neg ? RADIX_W'(-radix_q) : RADIX_W'(radix_q);
  assign radix_bad = (radix_mag < MIN_RADIX) || (radix_mag > RADIX_W'(MAX_RADIX));

  // digit from the remainder of a finished division pass
  logic             fix_up;
  logic [REM_W-1:0] digit_full;
  logic [CW-1:0]    count_inc;
  logic             quo_nz;
  logic             more;

  assign fix_up     = neg_q && (dp_st.rem != '0);
  assign digit_full = fix_up ? (radix_mag[REM_W-1:0] - dp_st.rem) : dp_st.rem;
  assign count_inc  = count_q + CW'(1);
  assign quo_nz     = dp_st.nz || fix_up;
  assign more       = quo_nz && (count_inc < CW'(MAX_DIGITS));

  logic in_accept;
  logic out_free;

  assign in_accept = in_valid_i && state_q == S_IDLE;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    neg_d        = neg_q;
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    dp_cmd       = '0;
    dp_load_data = value_i[VALUE_W-1] ? ~value_i : value_i;
    ram_we       = 1'b0;
    ram_wdata    = digit_full[DIGIT_W-1:0];
    out_valid_d  = out_valid_q && out_stall_i;
    digit_d      = digit_q;
    last_d       = last_q;
    bad_d        = bad_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (radix_bad) begin
            state_d = S_ERR;
          end else begin
            dp_cmd.load = 1'b1;
            neg_d       = value_i[VALUE_W-1];
            count_d     = '0;
            if (value_i[VALUE_W-1]) begin
              // two's complement magnitude: inverted word plus one
              dp_cmd.start_inc = 1'b1;
              state_d          = S_NEG;
            end else begin
              dp_cmd.start_div = 1'b1;
              state_d          = S_DIV;
            end
          end
        end
      end
      S_NEG: begin
        if (dp_st.done) begin
          dp_cmd.start_div = 1'b1;
          state_d          = S_DIV;
        end
      end
      S_DIV: begin
        if (dp_st.done) begin
          ram_we  = 1'b1;
          count_d = count_inc;
          neg_d   = quo_nz && (neg_q != radix_neg);
          if (more) begin
            if (fix_up) begin
              // quotient of the raised value is one more
              dp_cmd.start_inc = 1'b1;
              state_d          = S_INC;
            end else begin
              dp_cmd.start_div = 1'b1;
            end
          end else begin
            rd_idx_d = count_q[AW-1:0];
            state_d  = S_READ;
          end
        end
      end
      S_INC: begin
        if (dp_st.done) begin
          dp_cmd.start_div = 1'b1;
          state_d          = S_DIV;
        end
      end
      S_READ: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          digit_d     = ram_rdata;
          last_d      = (rd_idx_q == '0);
          bad_d       = 1'b0;
          if (rd_idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - AW'(1);
            state_d  = S_READ;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          digit_d     = '0;
          last_d      = 1'b1;
          bad_d       = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radix_q     <= RESET_RADIX;
      neg_q       <= 1'b0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        radix_q <= radix_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    last_q  <= last_d;
    bad_q   <= bad_d;
  end

  rdc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .load_data_i (dp_load_data),
    .divisor_i   (radix_mag[REM_W-1:0]),
    .status_o    (dp_st)
  );

  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign digit_o      = digit_q;
  assign last_digit_o = last_q;
  assign bad_radix_o  = bad_q;

endmodule
`default_nettype wire

// ===== sv/rdc_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rdc_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/rdc_dp.sv =====
// Nibble-serial datapath: long division by a small divisor and increment.
`default_nettype none
module rdc_dp import rdc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  input  wire logic [VALUE_W-1:0] load_data_i,
  input  wire logic [REM_W-1:0]   divisor_i,
  output dp_status_t              status_o
);

  logic [VALUE_W-1:0]   mag_q, mag_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic                 nz_q, nz_d;
  logic                 carry_q, carry_d;
  logic                 inc_mode_q, inc_mode_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [NIB_CNT_W-1:0] nib_cnt_q, nib_cnt_d;

  // Four restoring steps on the top nibble.
  logic [REM_W-1:0] div_rem;
  logic [NIB_W-1:0] div_quo;
  logic [REM_W:0]   trial;

  always_comb begin
    div_rem = rem_q;
    div_quo = '0;
    trial   = '0;
    for (int i = NIB_W - 1; i >= 0; i--) begin
      trial = {div_rem, mag_q[VALUE_W - NIB_W + i]};
      if (trial >= {1'b0, divisor_i}) begin
        trial      = trial - {1'b0, divisor_i};
        div_quo[i] = 1'b1;
      end
      div_rem = trial[REM_W-1:0];
    end
  end

  logic [NIB_W:0] inc_sum;
  assign inc_sum = {1'b0, mag_q[NIB_W-1:0]} + {{NIB_W{1'b0}}, carry_q};

  always_comb begin
    mag_d      = mag_q;
    rem_d      = rem_q;
    nz_d       = nz_q;
    carry_d    = carry_q;
    inc_mode_d = inc_mode_q;
    busy_d     = busy_q;
    done_d     = 1'b0;
    nib_cnt_d  = nib_cnt_q;

    if (cmd_i.load) begin
      mag_d = load_data_i;
    end

    if (cmd_i.start_div) begin
      busy_d     = 1'b1;
      inc_mode_d = 1'b0;
      rem_d      = '0;
      nz_d       = 1'b0;
      nib_cnt_d  = '0;
    end else if (cmd_i.start_inc) begin
      busy_d     = 1'b1;
      inc_mode_d = 1'b1;
      carry_d    = 1'b1;
      nib_cnt_d  = '0;
    end else if (busy_q) begin
      if (inc_mode_q) begin
        // rotate right; the word is back in place after a full pass
        mag_d   = {inc_sum[NIB_W-1:0], mag_q[VALUE_W-1:NIB_W]};
        carry_d = inc_sum[NIB_W];
      end else begin
        // quotient nibbles enter at the bottom as the dividend leaves the top
        mag_d = {mag_q[VALUE_W-NIB_W-1:0], div_quo};
        rem_d = div_rem;
        nz_d  = nz_q | (div_quo != '0);
      end
      nib_cnt_d = nib_cnt_q + NIB_CNT_W'(1);
      if (nib_cnt_q == NIB_CNT_W'(NIBBLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      done_q     <= 1'b0;
      inc_mode_q <= 1'b0;
      nib_cnt_q  <= '0;
    end else begin
      busy_q     <= busy_d;
      done_q     <= done_d;
      inc_mode_q <= inc_mode_d;
      nib_cnt_q  <= nib_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    rem_q   <= rem_d;
    nz_q    <= nz_d;
    carry_q <= carry_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign status_o.nz   = nz_q;
  assign status_o.rem  = rem_q;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the radix digit converter: digit prediction, stimulus and checks.
`default_nettype none
module testbench import rdc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIGITS = 64;
  localparam int unsigned MAX_RADIX  = 16;
  localparam int unsigned HOLD_CYCLES = 2500;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last_digit;
    logic               bad_radix;
  } digit_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic signed [RADIX_W-1:0] radix_i = RESET_RADIX;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [DIGIT_W-1:0]        digit_o;
  logic                      last_digit_o;
  logic                      bad_radix_o;

  // predictor state
  logic signed [RADIX_W-1:0] radix_setting = RESET_RADIX;
  digit_result_t             pending_digits[$];
  digit_result_t             oldest_digit;

  int  error_count = 0;
  int  values_sent = 0;
  int  digits_checked = 0;
  int  radix_writes = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_cycles_req = 0;
  int  hold_left = 0;
  bit  offering = 1'b0;

  radix_digit_converter_top #(
    .MAX_DIGITS(MAX_DIGITS),
    .MAX_RADIX (MAX_RADIX)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .radix_i     (radix_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .digit_o     (digit_o),
    .last_digit_o(last_digit_o),
    .bad_radix_o (bad_radix_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void expect_digit(input logic [DIGIT_W-1:0] d, input logic last,
                                       input logic bad);
    digit_result_t res;
    res.digit      = d;
    res.last_digit = last;
    res.bad_radix  = bad;
    pending_digits.insert(pending_digits.size(), res);
  endfunction

  // Digits of v in the current signed radix, most significant first.
  function automatic void predict_digits(input logic [VALUE_W-1:0] v);
    int                 b;
    bit                 radix_neg;
    bit                 run_neg;
    logic [63:0]        m;
    logic [63:0]        mag;
    logic [63:0]        r;
    logic [63:0]        d;
    logic [63:0]        reduced;
    logic [DIGIT_W-1:0] lsd_first[$];
    b = int'(radix_setting);
    radix_neg = (b < 0);
    m = 64'(radix_neg ? -b : b);
    if (m < MIN_RADIX || m > MAX_RADIX) begin
      expect_digit('0, 1'b1, 1'b1);
      return;
    end
    run_neg = v[VALUE_W-1];
    mag = run_neg ? (~v + 64'd1) : v;
    if (mag == 0) begin
      expect_digit('0, 1'b1, 1'b0);
      return;
    end
    // remainder is taken non-negative; the sign of the running value flips
    // with each division by a negative radix
    while (mag != 0 && lsd_first.size() < MAX_DIGITS) begin
      r = mag % m;
      if (!run_neg) begin
        d = r;
        reduced = mag - d;
      end else begin
        d = (r != 0) ? m - r : 64'd0;
        reduced = mag + d;
      end
      lsd_first.insert(lsd_first.size(), d[DIGIT_W-1:0]);
      mag = reduced / m;
      run_neg = (mag != 0) && (run_neg != radix_neg);
    end
    for (int k = lsd_first.size() - 1; k >= 0; k--) begin
      expect_digit(lsd_first[k], k == 0, 1'b0);
    end
  endfunction

  // Output side: check each accepted digit transaction, then choose next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected digit transaction: digit %0d last_digit %0b bad_radix %0b",
               digit_o, last_digit_o, bad_radix_o);
        error_count++;
      end else begin
        oldest_digit = pending_digits.pop_front();
        if (digit_o !== oldest_digit.digit) begin
          $error("digit: expected %0d, got %0d", oldest_digit.digit, digit_o);
          error_count++;
        end
        if (last_digit_o !== oldest_digit.last_digit) begin
          $error("last_digit: expected %0b, got %0b", oldest_digit.last_digit, last_digit_o);
          error_count++;
        end
        if (bad_radix_o !== oldest_digit.bad_radix) begin
          $error("bad_radix: expected %0b, got %0b", oldest_digit.bad_radix, bad_radix_o);
          error_count++;
        end
        digits_checked++;
      end
    end
    if (hold_cycles_req != 0) begin
      hold_left = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one value and wait until the block takes it.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      if (offering) begin
        in_valid_i <= 1'b0;
        offering = 1'b0;
      end
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_digits(v);
    values_sent++;
  endtask

  task automatic wait_for_idle();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    while (pending_digits.size() != 0) @(posedge clk_i);
  endtask

  // Radix is only written once every digit has come out.
  task automatic set_radix(input logic signed [RADIX_W-1:0] r);
    wait_for_idle();
    cfg_valid_i <= 1'b1;
    radix_i     <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    radix_setting = r;
    radix_writes++;
  endtask

  function automatic logic signed [RADIX_W-1:0] random_radix();
    logic signed [RADIX_W-1:0] r;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(6))
        0:       r = 6'sd0;
        1:       r = 6'sd1;
        2:       r = -6'sd1;
        3:       r = 6'sd17;
        4:       r = 6'sd31;
        5:       r = -6'sd17;
        default: r = -6'sd32;
      endcase
    end else begin
      r = RADIX_W'($urandom_range(2, MAX_RADIX));
      if ($urandom_range(1)) r = -r;
    end
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return '0;
      1: begin
        case ($urandom_range(3))
          0:       return 64'h8000_0000_0000_0000;
          1:       return 64'h7FFF_FFFF_FFFF_FFFF;
          2:       return '1;
          default: return 64'd1;
        endcase
      end
      2, 3: raw = VALUE_W'($urandom_range(300));
      default: raw = raw >> $urandom_range(63);
    endcase
    return $urandom_range(1) ? -raw : raw;
  endfunction

  task automatic check_reset_radix();
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(-64'd10);
  endtask

  task automatic check_radix_extremes();
    logic signed [RADIX_W-1:0] extremes[4];
    extremes = '{6'sd2, -6'sd2, 6'sd16, -6'sd16};
    foreach (extremes[i]) begin
      set_radix(extremes[i]);
      // max positive in radix -2 overflows 64 digits and gets truncated
      send_value(64'h7FFF_FFFF_FFFF_FFFF);
      send_value(64'h8000_0000_0000_0000);
      send_value('1);
    end
  endtask

  task automatic check_rejected_radix();
    logic signed [RADIX_W-1:0] rejected[6];
    rejected = '{6'sd0, 6'sd1, -6'sd1, 6'sd17, 6'sd31, -6'sd32};
    foreach (rejected[i]) begin
      set_radix(rejected[i]);
      send_value(random_value());
    end
  endtask

  // Receiver holds off while values keep coming, so the input stalls.
  task automatic check_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_radix(-6'sd2);
    hold_cycles_req = HOLD_CYCLES;
    repeat (6) send_value({$urandom, $urandom});
  endtask

  task automatic check_random_conversions();
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int phase = 0; phase < 4; phase++) begin
        set_radix(random_radix());
        repeat (28) send_value(random_value());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 34;
    recv_idle_pct = 85;
    check_reset_radix();
    check_radix_extremes();
    check_rejected_radix();
    check_output_backpressure();
    check_random_conversions();
    wait_for_idle();
    repeat (200) @(posedge clk_i);
    if (pending_digits.size() != 0) begin
      $error("%0d expected digit transactions never arrived", pending_digits.size());
      error_count++;
    end
    $display("summary: %0d values converted under %0d radix writes, %0d digits checked",
             values_sent, radix_writes, digits_checked);
    $display("summary: signed and rejected radices, extreme values, truncation, %0d-cycle hold",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("timeout with %0d digit transactions outstanding", pending_digits.size());
    $display("testbench: errors");
    $finish;
  end

endmodule
`default_nettype wire
